// ===== src/lmbs_pkg.sv =====
// Shared types and constants for the LED matrix bit-plane scanner.
package lmbs_pkg;

    // Default geometry and color depth
    localparam int DEF_PANEL_WIDTH  = 64;
    localparam int DEF_PANEL_HEIGHT = 32;
    localparam int DEF_SCAN_DIVIDER = 16;
    localparam int DEF_COLOR_DEPTH  = 8;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int WORD_W     = 32;
    localparam int BITPOS_W   = $clog2(WORD_W);
    localparam int ROW_SEL_W  = 4;
    localparam int CMP_W      = 16;
    localparam int PLANE_W    = 3;
    localparam int GAMMA_DEPTH = 256;

    localparam logic [CMP_W-1:0] RELOAD_RESET = 16'd1000;
    localparam logic [CMP_W-1:0] PWM_OFFSET   = 16'd220;

    // Request codes
    typedef enum logic [1:0] {
        REQ_PIXEL   = 2'd0,
        REQ_GAMMA   = 2'd1,
        REQ_REFRESH = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    // Color plane codes
    localparam logic [1:0] CH_FIRST  = 2'd0;
    localparam logic [1:0] CH_SECOND = 2'd1;
    localparam logic [1:0] CH_THIRD  = 2'd2;

    // Request payload
    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] channel;
        logic [4:0] row;
        logic [5:0] column;
        logic [7:0] pixel_value;
        logic [7:0] lut_index;
        logic [7:0] lut_value;
    } req_t;

    // Line word payload
    typedef struct packed {
        logic [WORD_W-1:0]    data_word;
        logic                 last;
        logic                 latch;
        logic [ROW_SEL_W-1:0] row_select;
        logic [CMP_W-1:0]     compare_value;
    } line_t;

    // Shift order of the color planes: first, third, second
    function automatic logic [1:0] walk_plane(input logic [1:0] step);
        logic [1:0] ch;
        case (step)
            2'd0:    ch = CH_FIRST;
            2'd1:    ch = CH_THIRD;
            2'd2:    ch = CH_SECOND;
            default: ch = CH_FIRST;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/lmbs_ram.sv =====
// Generic simple dual-port RAM with registered read and read enable.
module lmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/led_matrix_bitplane_scanner.sv =====
// Top level: frame store, gamma table and line word generator.
//
//  channel | signals                         | transfer when
//  --------+---------------------------------+----------------------------
//  request | req_valid, req_ready, req_data  | req_valid & req_ready
//  line    | line_valid, line_ready, line_data | line_valid & line_ready
//  config  | cfg_write, cfg_data             | cfg_write
//
// After reset the frame store is swept to zero, one entry per cycle, with
// req_ready low. A refresh issues one frame store read per cycle unless
// stalled: (PANEL_HEIGHT / SCAN_DIVIDER) * 3 * PANEL_WIDTH reads (384 at
// defaults), which drain through the frame store and gamma table reads; the
// final word reaches the line register as req_ready returns.
// A full line register that is not taken stalls the read pipeline in place.
module led_matrix_bitplane_scanner #(
    parameter int PANEL_WIDTH  = lmbs_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = lmbs_pkg::DEF_PANEL_HEIGHT,
    parameter int SCAN_DIVIDER = lmbs_pkg::DEF_SCAN_DIVIDER,
    parameter int COLOR_DEPTH  = lmbs_pkg::DEF_COLOR_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  lmbs_pkg::req_t  req_data,
    output logic            line_valid,
    input  logic            line_ready,
    output lmbs_pkg::line_t line_data,
    input  logic            cfg_write,
    input  logic [15:0]     cfg_data
);

    import lmbs_pkg::*;

    localparam int PLANE_SIZE  = PANEL_HEIGHT * PANEL_WIDTH;
    localparam int STORE_DEPTH = 3 * PLANE_SIZE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GROUP_COUNT = PANEL_HEIGHT / SCAN_DIVIDER;
    localparam int GROUP_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int COL_W       = $clog2(PANEL_WIDTH);
    localparam int ROW_W       = $clog2(PANEL_HEIGHT);
    localparam int LINE_BITS   = GROUP_COUNT * 3 * PANEL_WIDTH;
    localparam int LAST_POS    = (LINE_BITS - 1) % WORD_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t                 state_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [COL_W-1:0]       col_reg;
    logic [1:0]             step_reg;
    logic [GROUP_W-1:0]     group_reg;
    logic [ROW_SEL_W-1:0]   scan_row_reg;
    logic [PLANE_W-1:0]     plane_bit_reg;
    logic [CMP_W-1:0]       reload_reg;
    logic [CMP_W-1:0]       cmp_reg;
    logic [WORD_W-1:0]      word_reg;
    logic [BITPOS_W-1:0]    bitpos_reg;
    logic                   line_valid_reg;
    line_t                  line_reg;

    // Read pipeline: stage 1 waits on frame store, stage 2 on gamma table
    logic                   s1_valid_reg;
    logic                   s1_final_reg;
    logic                   s2_valid_reg;
    logic                   s2_final_reg;

    logic                   req_xfer;
    logic                   issue;
    logic                   issue_final;
    logic                   stall;
    logic                   word_done;
    logic                   pix_in_range;
    logic [ROW_W-1:0]       scan_line;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   pix_wr_en;
    logic [PIX_W-1:0]       pix_wr_data;
    logic [PIX_W-1:0]       pix_rd_data;
    logic [PIX_W-1:0]       gamma_rd_data;
    logic                   gamma_wr_en;
    logic [WORD_W-1:0]      word_next;
    logic [PLANE_W-1:0]     shift_amt;
    logic [CMP_W-1:0]       span;
    logic [CMP_W-1:0]       cmp_next;
    logic [ROW_SEL_W-1:0]   scan_row_next;
    logic [PLANE_W-1:0]     plane_bit_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign issue     = (state_reg == ST_ISSUE);

    // Last read of the line
    assign issue_final = (int'(col_reg) == PANEL_WIDTH - 1) && (step_reg == 2'd2)
                      && (int'(group_reg) == GROUP_COUNT - 1);

    // Frame store read address for the current group, plane and column
    always_comb
    begin
        scan_line = ROW_W'(scan_row_reg) + ROW_W'(int'(group_reg) * SCAN_DIVIDER);
        rd_addr   = ADDR_W'(walk_plane(step_reg)) * ADDR_W'(PLANE_SIZE)
                  + ADDR_W'(scan_line) * ADDR_W'(PANEL_WIDTH)
                  + ADDR_W'(col_reg);
    end

    // Frame store write: clearing sweep or pixel transfer
    always_comb
    begin
        pix_in_range = (req_data.channel <= CH_THIRD)
                    && (int'(req_data.row) < PANEL_HEIGHT)
                    && (int'(req_data.column) < PANEL_WIDTH);
        if (state_reg == ST_CLEAR)
        begin
            pix_wr_en   = 1'b1;
            wr_addr     = clr_addr_reg;
            pix_wr_data = '0;
        end
        else
        begin
            pix_wr_en   = req_xfer && (req_data.req_type == REQ_PIXEL) && pix_in_range;
            wr_addr     = ADDR_W'(req_data.channel) * ADDR_W'(PLANE_SIZE)
                        + ADDR_W'(req_data.row) * ADDR_W'(PANEL_WIDTH)
                        + ADDR_W'(req_data.column);
            pix_wr_data = req_data.pixel_value;
        end
    end

    assign gamma_wr_en = req_xfer && (req_data.req_type == REQ_GAMMA);

    // Packing of the next line bit
    always_comb
    begin
        word_next = word_reg;
        word_next[bitpos_reg] = gamma_rd_data[plane_bit_reg];
    end

    assign word_done = (bitpos_reg == BITPOS_W'(WORD_W - 1)) || s2_final_reg;
    assign stall     = s2_valid_reg && word_done && line_valid_reg && !line_ready;

    // Compare value for the current bit plane
    always_comb
    begin
        shift_amt = PLANE_W'(COLOR_DEPTH - 1) - plane_bit_reg;
        span      = reload_reg - PWM_OFFSET;
        cmp_next  = reload_reg - (span >> shift_amt);
    end

    // Row and bit-plane advance at the end of a line
    always_comb
    begin
        scan_row_next  = scan_row_reg + ROW_SEL_W'(1);
        plane_bit_next = plane_bit_reg;
        if (int'(scan_row_reg) == SCAN_DIVIDER - 1)
        begin
            scan_row_next = '0;
            if (int'(plane_bit_reg) == COLOR_DEPTH - 1)
            begin
                plane_bit_next = '0;
            end
            else
            begin
                plane_bit_next = plane_bit_reg + PLANE_W'(1);
            end
        end
    end

    lmbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_pixel_store (
        .clk     (clk),
        .wr_en   (pix_wr_en),
        .wr_addr (wr_addr),
        .wr_data (pix_wr_data),
        .rd_en   (!stall),
        .rd_addr (rd_addr),
        .rd_data (pix_rd_data)
    );

    lmbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (GAMMA_DEPTH)
    ) u_gamma_table (
        .clk     (clk),
        .wr_en   (gamma_wr_en),
        .wr_addr (req_data.lut_index),
        .wr_data (req_data.lut_value),
        .rd_en   (!stall),
        .rd_addr (pix_rd_data),
        .rd_data (gamma_rd_data)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= RELOAD_RESET;
        end
        else if (cfg_write)
        begin
            reload_reg <= cfg_data;
        end
    end

    // Read pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_final_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_final_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= issue;
            s1_final_reg <= issue && issue_final;
            s2_valid_reg <= s1_valid_reg;
            s2_final_reg <= s1_final_reg;
        end
    end

    // Sequencer, packer and line register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            col_reg        <= '0;
            step_reg       <= '0;
            group_reg      <= '0;
            scan_row_reg   <= '0;
            plane_bit_reg  <= '0;
            cmp_reg        <= '0;
            word_reg       <= '0;
            bitpos_reg     <= '0;
            line_valid_reg <= 1'b0;
            line_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (int'(clr_addr_reg) == STORE_DEPTH - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_xfer && (req_data.req_type == REQ_REFRESH))
                    begin
                        col_reg    <= '0;
                        step_reg   <= '0;
                        group_reg  <= '0;
                        word_reg   <= '0;
                        bitpos_reg <= '0;
                        cmp_reg    <= cmp_next;
                        state_reg  <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (!stall)
                    begin
                        if (issue_final)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else if (int'(col_reg) == PANEL_WIDTH - 1)
                        begin
                            col_reg <= '0;
                            if (step_reg == 2'd2)
                            begin
                                step_reg  <= '0;
                                group_reg <= group_reg + GROUP_W'(1);
                            end
                            else
                            begin
                                step_reg <= step_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + COL_W'(1);
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (s2_valid_reg && s2_final_reg && !stall)
                    begin
                        scan_row_reg  <= scan_row_next;
                        plane_bit_reg <= plane_bit_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Bit packer; a full or final word goes to the line register
            if (s2_valid_reg && !stall && word_done)
            begin
                line_valid_reg          <= 1'b1;
                line_reg.data_word      <= word_next;
                line_reg.last           <= s2_final_reg;
                line_reg.latch          <= s2_final_reg;
                line_reg.row_select     <= s2_final_reg ? scan_row_reg : '0;
                line_reg.compare_value  <= s2_final_reg ? cmp_reg : '0;
                word_reg                <= '0;
                bitpos_reg              <= '0;
            end
            else
            begin
                if (line_valid_reg && line_ready)
                begin
                    line_valid_reg <= 1'b0;
                end
                if (s2_valid_reg && !stall)
                begin
                    word_reg   <= word_next;
                    bitpos_reg <= bitpos_reg + BITPOS_W'(1);
                end
            end
        end
    end

    assign line_valid = line_valid_reg;
    assign line_data  = line_reg;

    // No new request while line reads are still in flight
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("request taken with reads in flight");

    // The final bit of a line lands at the expected word position
    a_final_bitpos: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_final_reg) |-> (bitpos_reg == BITPOS_W'(LAST_POS)))
        else $error("line length and packed bit count disagree");

    // Frame store writes never overlap a refresh read sequence
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pix_wr_en |-> (!issue && !s1_valid_reg))
        else $error("frame store write during refresh");

    // A stall freezes the read address
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stall && issue) |=> $stable(rd_addr))
        else $error("read address moved during stall");

endmodule

// ===== verif/lmbs_checker.sv =====
// Line word checker for the LED matrix bit-plane scanner: tracks state, predicts and compares.
`timescale 1ns / 100ps

module lmbs_checker
    import lmbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_t        req_data,
    input  logic        line_valid,
    input  logic        line_ready,
    input  line_t       line_data,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    output int          pending,
    output int          errors
);

    localparam int COLS       = DEF_PANEL_WIDTH;
    localparam int ROWS       = DEF_PANEL_HEIGHT;
    localparam int DIV        = DEF_SCAN_DIVIDER;
    localparam int DEPTH      = DEF_COLOR_DEPTH;
    localparam int GROUPS     = ROWS / DIV;
    localparam int LINE_LEN   = GROUPS * 3 * COLS;
    localparam int WORDS      = (LINE_LEN + WORD_W - 1) / WORD_W;

    // Plane shift order packed two bits per step: first, third, second
    localparam logic [5:0] SHIFT_ORDER = {CH_SECOND, CH_THIRD, CH_FIRST};

    // Shadow state of the block
    logic [PIX_W-1:0] frame_mem [3][ROWS][COLS];
    logic [PIX_W-1:0] gamma_mem [GAMMA_DEPTH];
    int               scan_row_q;
    int               plane_q;
    logic [CMP_W-1:0] reload_q;

    line_t line_q [$];
    line_t want_word;
    int    mismatch_count = 0;

    assign errors = mismatch_count;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t ns: line word %s mismatch, got %h expected %h",
                 $time, what, got, want);
        mismatch_count++;
    endtask

    // Build the line words for the current row and bit plane, then step the counters
    task automatic predict_line();
        logic [WORD_W-1:0] bits [WORDS];
        line_t             word_out;
        logic [CMP_W-1:0]  span;
        logic [CMP_W-1:0]  cmp;
        logic [1:0]        plane_sel;
        logic [PIX_W-1:0]  lit;
        int                pos;
        int                r;
        pos = 0;
        for (int k = 0; k < WORDS; k++)
            bits[k] = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            r = scan_row_q + g * DIV;
            for (int p = 0; p < 3; p++)
            begin
                plane_sel = SHIFT_ORDER[2*p +: 2];
                for (int c = 0; c < COLS; c++)
                begin
                    lit = gamma_mem[frame_mem[plane_sel][r][c]];
                    bits[pos / WORD_W][pos % WORD_W] = lit[plane_q];
                    pos++;
                end
            end
        end

        // compare value wraps modulo 2^16 for small reload values
        span = reload_q - PWM_OFFSET;
        cmp  = reload_q - (span >> (DEPTH - 1 - plane_q));

        for (int k = 0; k < WORDS; k++)
        begin
            word_out.data_word     = bits[k];
            word_out.last          = (k == WORDS - 1);
            word_out.latch         = (k == WORDS - 1);
            word_out.row_select    = (k == WORDS - 1) ? ROW_SEL_W'(scan_row_q) : '0;
            word_out.compare_value = (k == WORDS - 1) ? cmp : '0;
            line_q.push_back(word_out);
        end

        if (scan_row_q == DIV - 1)
        begin
            scan_row_q = 0;
            plane_q    = (plane_q == DEPTH - 1) ? 0 : plane_q + 1;
        end
        else
            scan_row_q++;
    endtask

    // Watch the three ports at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 3; p++)
                for (int r = 0; r < ROWS; r++)
                    for (int c = 0; c < COLS; c++)
                        frame_mem[p][r][c] = '0;
            for (int i = 0; i < GAMMA_DEPTH; i++)
                gamma_mem[i] = '0;
            scan_row_q = 0;
            plane_q    = 0;
            reload_q   = RELOAD_RESET;
            line_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
                reload_q = cfg_data;

            // line transfer: compare against the oldest expected word
            if (line_valid && line_ready)
            begin
                if (line_q.size() == 0)
                    report_mismatch("unexpected", line_data.data_word, '0);
                else
                begin
                    want_word = line_q.pop_front();
                    if (line_data.data_word !== want_word.data_word)
                        report_mismatch("data_word", line_data.data_word,
                                        want_word.data_word);
                    if (line_data.last !== want_word.last)
                        report_mismatch("last", WORD_W'(line_data.last),
                                        WORD_W'(want_word.last));
                    if (line_data.latch !== want_word.latch)
                        report_mismatch("latch", WORD_W'(line_data.latch),
                                        WORD_W'(want_word.latch));
                    if (line_data.row_select !== want_word.row_select)
                        report_mismatch("row_select", WORD_W'(line_data.row_select),
                                        WORD_W'(want_word.row_select));
                    if (line_data.compare_value !== want_word.compare_value)
                        report_mismatch("compare_value", WORD_W'(line_data.compare_value),
                                        WORD_W'(want_word.compare_value));
                end
            end

            // request transfer: update the shadow state
            if (req_valid && req_ready)
            begin
                case (req_data.req_type)
                    REQ_PIXEL:
                        if (req_data.channel <= CH_THIRD && int'(req_data.row) < ROWS
                            && int'(req_data.column) < COLS)
                            frame_mem[req_data.channel][req_data.row][req_data.column]
                                = req_data.pixel_value;
                    REQ_GAMMA:
                        gamma_mem[req_data.lut_index] = req_data.lut_value;
                    REQ_REFRESH:
                        predict_line();
                    default: ;
                endcase
            end

            pending <= line_q.size();
        end
    end

endmodule

// ===== verif/tb_led_matrix_bitplane_scanner.sv =====
// Testbench top for the LED matrix bit-plane scanner: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_led_matrix_bitplane_scanner;
    import lmbs_pkg::*;

    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         SETTLE      = 16;
    localparam int         LONG_STALL  = 3000;
    localparam logic [1:0] CH_UNUSED   = 2'd3;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid;
    logic        req_ready;
    req_t        req_data;
    logic        line_valid;
    logic        line_ready = 1'b0;
    line_t       line_data;
    logic        cfg_write;
    logic [15:0] cfg_data;
    int          pending;
    int          errors;

    int   cycle_count   = 0;
    int   tx_idle       = 0;
    int   rx_idle       = 0;
    logic hold_on       = 1'b0;
    bit   stall_go      = 1'b0;
    bit   lut_loaded [GAMMA_DEPTH];
    int   refresh_count = 0;

    always #1 clk = ~clk;

    led_matrix_bitplane_scanner u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_data  (line_data),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data)
    );

    lmbs_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_data  (line_data),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .errors     (errors)
    );

    // Receiver: random back-pressure, forced low during the long hold-off
    always @(posedge clk)
    begin
        if (hold_on)
            line_ready <= 1'b0;
        else
            line_ready <= ($urandom_range(99) >= rx_idle);
    end

    // Long receiver hold-off so the line path fills and the request side stalls
    initial
    begin
        wait (stall_go);
        hold_on <= 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic req_t noise_item();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return noise[$bits(req_t)-1:0];
    endfunction

    function automatic req_t pixel_req(input logic [1:0] ch, input logic [4:0] r,
                                       input logic [5:0] c, input logic [7:0] v);
        req_t item;
        item             = noise_item();
        item.req_type    = REQ_PIXEL;
        item.channel     = ch;
        item.row         = r;
        item.column      = c;
        item.pixel_value = v;
        return item;
    endfunction

    function automatic req_t gamma_req(input logic [7:0] idx, input logic [7:0] v);
        req_t item;
        item           = noise_item();
        item.req_type  = REQ_GAMMA;
        item.lut_index = idx;
        item.lut_value = v;
        return item;
    endfunction

    function automatic req_t refresh_req();
        req_t item;
        item          = noise_item();
        item.req_type = REQ_REFRESH;
        return item;
    endfunction

    // Mix: mostly refreshes and pixel writes, half of them aimed at the rows of the next line
    function automatic req_t random_item();
        req_t       item;
        int         pick;
        logic [4:0] row_pick;
        pick     = $urandom_range(99);
        row_pick = 5'($urandom);
        if ($urandom_range(1))
            row_pick = 5'((refresh_count % DEF_SCAN_DIVIDER)
                          + DEF_SCAN_DIVIDER * $urandom_range(1));
        if (pick < 50)
            return refresh_req();
        if (pick < 80)
            return pixel_req(2'($urandom_range(2)), row_pick, 6'($urandom), 8'($urandom));
        if (pick < 92)
            return gamma_req(8'($urandom), 8'($urandom));
        if (pick < 96)
            return pixel_req(CH_UNUSED, row_pick, 6'($urandom), 8'($urandom));
        item          = noise_item();
        item.req_type = REQ_NONE;
        return item;
    endfunction

    // One request transfer, with random idle cycles ahead of it
    task automatic transfer(input req_t item);
        while ($urandom_range(99) < tx_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Loads a gamma entry first whenever a stored pixel would map through an unloaded one
    task automatic send(input req_t item);
        if (item.req_type == REQ_PIXEL && item.channel != CH_UNUSED
            && !lut_loaded[item.pixel_value])
        begin
            lut_loaded[item.pixel_value] = 1'b1;
            transfer(gamma_req(item.pixel_value, 8'($urandom)));
        end
        if (item.req_type == REQ_GAMMA)
            lut_loaded[item.lut_index] = 1'b1;
        if (item.req_type == REQ_REFRESH)
            refresh_count++;
        transfer(item);
    endtask

    // Stop sending and wait for every expected line word, then let the block settle
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reload(input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int tx, input int rx);
        tx_idle = tx;
        rx_idle <= rx;
        repeat (count) send(random_item());
        wait_idle();
    endtask

    initial
    begin
        req_valid <= 1'b0;
        req_data  <= '0;
        cfg_write <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: gamma extremes, pixel corners, ignored requests
        send(gamma_req(8'd0, 8'hA5));
        send(gamma_req(8'd255, 8'hFF));
        send(gamma_req(8'd128, 8'h5A));
        send(gamma_req(8'd1, 8'h01));
        send(pixel_req(CH_FIRST, 5'd0, 6'd0, 8'd255));
        send(pixel_req(CH_SECOND, 5'd0, 6'd0, 8'd255));
        send(pixel_req(CH_THIRD, 5'd0, 6'd32, 8'd128));
        send(pixel_req(CH_SECOND, 5'd16, 6'd63, 8'd1));
        send(pixel_req(CH_THIRD, 5'd31, 6'd63, 8'd128));
        send(pixel_req(CH_UNUSED, 5'd0, 6'd1, 8'd0));
        send(random_item());
        send(refresh_req());
        send(refresh_req());

        // Directed: reload extremes, including values below the offset
        wait_idle();
        write_reload(16'd221);
        send(refresh_req());
        wait_idle();
        write_reload(16'hFFFF);
        send(refresh_req());
        wait_idle();
        write_reload(16'd0);
        send(refresh_req());
        wait_idle();
        write_reload(16'd219);
        send(refresh_req());
        wait_idle();
        write_reload(16'd220);
        send(refresh_req());
        wait_idle();

        // Random phases with different idling
        write_reload(16'($urandom));
        run_phase(60, 9, 68);
        write_reload(16'($urandom_range(65535, 221)));
        run_phase(60, 68, 9);
        write_reload(16'($urandom));
        stall_go = 1'b1;
        run_phase(65, 0, 0);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
